// ===== rtl/core/fdf_pkg.sv =====
// shared types and constants of the length framed byte deframer
// no dependencies; used by the front, queue, back and top modules by scoped names
`timescale 1ns / 1ps

package fdf_pkg;

  // framing bytes and fixed byte positions within a frame
  localparam logic [7:0] HDR_BYTE  = 8'hEF;
  localparam logic [7:0] TAIL_BYTE = 8'hFF;
  localparam int unsigned LEN_POS  = 5;
  localparam int unsigned NODE_POS = 6;
  localparam int unsigned DEV_POS  = 7;
  localparam int unsigned PAY_POS  = 8;

  // payload byte count width, large enough for any frame length byte
  localparam int unsigned CNT_W = 8;

  // one job handed from the front to the back
  typedef struct packed {
    logic             drop;
    logic [7:0]       node;
    logic [7:0]       device;
    logic [CNT_W-1:0] count;
  } job_t;

  // back end sequencer states
  typedef enum logic {
    BK_IDLE,
    BK_STREAM
  } bk_state_e;

endpackage

// ===== rtl/core/fdf_ram.sv =====
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module fdf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/fdf_front.sv =====
// front end: accepts received bytes, tracks the frame fill and header fields,
// writes the frame store and pushes frame and drop jobs; uses fdf_pkg
`timescale 1ns / 1ps

module fdf_front #(
  parameter int unsigned MAX_FRAME = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   in_byte_i,
  output logic                         we_o,
  output logic [$clog2(MAX_FRAME)-1:0] waddr_o,
  output logic [7:0]                   wdata_o,
  output logic                         push_o,
  output fdf_pkg::job_t                job_o,
  input  logic                         q_full_i,
  input  logic                         pay_done_i
);

  localparam int unsigned FW = $clog2(MAX_FRAME);

  logic [FW-1:0] fill_q, fill_d;
  logic [7:0]    last_q, last_d;
  logic [7:0]    len_q, len_d;
  logic [7:0]    node_q, node_d;
  logic [7:0]    dev_q, dev_d;
  logic          pend_q, pend_d;

  logic [8:0] fill9;
  logic       accept;
  logic       is_restart;
  logic       is_frame;
  logic       is_drop;
  logic       is_store;

  assign fill9 = 9'(fill_q);

  // byte classification
  assign is_restart = (in_byte_i == fdf_pkg::HDR_BYTE) && (fill_q != '0)
                      && (last_q == fdf_pkg::HDR_BYTE);
  assign is_frame   = !is_restart && (fill9 > 9'(fdf_pkg::LEN_POS))
                      && (in_byte_i == fdf_pkg::TAIL_BYTE)
                      && ((fill9 + 9'd1) == {1'b0, len_q});
  assign is_drop    = !is_restart && !is_frame && (fill9 >= 9'(MAX_FRAME - 1));
  assign is_store   = !is_restart && !is_frame && !is_drop;

  // hold off while the queue is full or the payload area is still being read
  assign in_ready_o = !q_full_i && !(pend_q && (fill9 >= 9'(fdf_pkg::PAY_POS)));
  assign accept     = in_valid_i && in_ready_o;

  // frame store write
  assign we_o    = accept && is_store;
  assign waddr_o = fill_q;
  assign wdata_o = in_byte_i;

  // job build
  always_comb begin
    job_o = '0;
    job_o.drop = is_drop;
    if (is_frame) begin
      job_o.node = node_q;
      job_o.device = dev_q;
      if (fill9 == 9'(fdf_pkg::NODE_POS)) begin
        job_o.node = fdf_pkg::TAIL_BYTE;
        job_o.device = 8'h00;
      end else if (fill9 == 9'(fdf_pkg::DEV_POS)) begin
        job_o.device = fdf_pkg::TAIL_BYTE;
      end
      if (fill9 > 9'(fdf_pkg::PAY_POS)) begin
        job_o.count = fdf_pkg::CNT_W'(fill9 - 9'(fdf_pkg::PAY_POS));
      end
    end
  end

  assign push_o = accept && (is_frame || is_drop);

  // next state of the fill tracking
  always_comb begin
    fill_d = fill_q;
    last_d = last_q;
    len_d  = len_q;
    node_d = node_q;
    dev_d  = dev_q;
    pend_d = pend_q;
    if (pay_done_i) begin
      pend_d = 1'b0;
    end
    if (accept) begin
      if (is_restart) begin
        fill_d = FW'(2);
        last_d = fdf_pkg::HDR_BYTE;
      end else if (is_frame || is_drop) begin
        fill_d = '0;
        if (is_frame && (job_o.count != '0)) begin
          pend_d = 1'b1;
        end
      end else begin
        fill_d = fill_q + FW'(1);
        last_d = in_byte_i;
        if (fill9 == 9'(fdf_pkg::LEN_POS)) begin
          len_d = in_byte_i;
        end
        if (fill9 == 9'(fdf_pkg::NODE_POS)) begin
          node_d = in_byte_i;
        end
        if (fill9 == 9'(fdf_pkg::DEV_POS)) begin
          dev_d = in_byte_i;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pend_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      pend_q <= pend_d;
    end
  end

  // header field registers
  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    len_q  <= len_d;
    node_q <= node_d;
    dev_q  <= dev_d;
  end

endmodule

// ===== rtl/core/fdf_queue.sv =====
// two entry job queue between the front and the back end
// uses fdf_pkg for the job type
`timescale 1ns / 1ps

module fdf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fdf_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output fdf_pkg::job_t job_o,
  output logic          empty_o
);

  fdf_pkg::job_t slot_q [2];
  logic          wp_q, wp_d;
  logic          rp_q, rp_d;
  logic [1:0]    cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign job_o   = slot_q[rp_q];

  // pointer and count update
  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = ~wp_q;
    end
    if (pop_i) begin
      rp_d = ~rp_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= job_i;
    end
  end

endmodule

// ===== rtl/core/fdf_back.sv =====
// back end: takes jobs, reads payload bytes from the frame store and drives
// the registered result stream; uses fdf_pkg
`timescale 1ns / 1ps

module fdf_back #(
  parameter int unsigned MAX_FRAME = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_empty_i,
  input  fdf_pkg::job_t                job_i,
  output logic                         pop_o,
  output logic                         re_o,
  output logic [$clog2(MAX_FRAME)-1:0] raddr_o,
  input  logic [7:0]                   rdata_i,
  output logic                         pay_done_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [23:0]                  out_data_o,
  output logic [1:0]                   out_user_o,
  output logic                         out_last_o
);

  localparam int unsigned AW = $clog2(MAX_FRAME);
  localparam int unsigned CW = fdf_pkg::CNT_W;

  fdf_pkg::bk_state_e state_q, state_d;

  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0]    node_q, node_d;
  logic [7:0]    dev_q, dev_d;
  logic          valid_q, valid_d;
  logic [23:0]   data_q, data_d;
  logic [1:0]    user_q, user_d;
  logic          last_q, last_d;

  logic out_free;
  logic is_last;

  assign out_free = !valid_q || out_ready_i;
  assign is_last  = (idx_q + CW'(1)) == cnt_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fdf_pkg::BK_IDLE: begin
        if (!q_empty_i && out_free && !job_i.drop && (job_i.count != '0)) begin
          state_d = fdf_pkg::BK_STREAM;
        end
      end
      fdf_pkg::BK_STREAM: begin
        if (out_free && is_last) begin
          state_d = fdf_pkg::BK_IDLE;
        end
      end
      default: state_d = fdf_pkg::BK_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    pop_o      = 1'b0;
    re_o       = 1'b0;
    raddr_o    = AW'(fdf_pkg::PAY_POS);
    pay_done_o = 1'b0;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    node_d     = node_q;
    dev_d      = dev_q;
    data_d     = data_q;
    user_d     = user_q;
    last_d     = last_q;
    valid_d    = valid_q && !out_ready_i;
    case (state_q)
      fdf_pkg::BK_IDLE: begin
        if (!q_empty_i && out_free) begin
          pop_o = 1'b1;
          if (job_i.drop) begin
            // overflow notice with all data fields zero
            valid_d = 1'b1;
            data_d  = '0;
            user_d  = 2'b01;
            last_d  = 1'b1;
          end else if (job_i.count == '0) begin
            // header-only frame, single result
            valid_d = 1'b1;
            data_d  = {8'h00, job_i.device, job_i.node};
            user_d  = 2'b00;
            last_d  = 1'b1;
          end else begin
            // fetch the first payload byte
            re_o   = 1'b1;
            idx_d  = '0;
            cnt_d  = job_i.count;
            node_d = job_i.node;
            dev_d  = job_i.device;
          end
        end
      end
      fdf_pkg::BK_STREAM: begin
        if (out_free) begin
          valid_d = 1'b1;
          data_d  = {rdata_i, dev_q, node_q};
          user_d  = 2'b10;
          last_d  = is_last;
          if (is_last) begin
            pay_done_o = 1'b1;
          end else begin
            // prefetch the next payload byte
            re_o    = 1'b1;
            raddr_o = AW'(9'(fdf_pkg::PAY_POS) + 9'(idx_q) + 9'd1);
            idx_d   = idx_q + CW'(1);
          end
        end
      end
      default: begin
        valid_d = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fdf_pkg::BK_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  // job and result registers
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    cnt_q  <= cnt_d;
    node_q <= node_d;
    dev_q  <= dev_d;
    data_q <= data_d;
    user_q <= user_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_user_o  = user_q;
  assign out_last_o  = last_q;

endmodule

// ===== rtl/core/length_framed_byte_deframer.sv =====
// Length framed byte deframer. Takes one received byte per transaction and
// rebuilds frames (two header bytes, spare, two address bytes, length, node,
// device, payload, tail 0xFF). A completed frame gives one result per payload
// byte (node and device repeated, tlast on the final one), or a single result
// without payload when the frame carries none; a frame that would outgrow
// MAX_FRAME bytes gives a single result flagged as dropped. Results of a frame
// come out at one per cycle while the sink is ready, after a fetch through
// the registered read port of the frame store. A two entry job queue lets
// bytes of the next frame arrive while results stream out; bytes wait while
// the queue is full, and once the fill reaches the payload positions they
// wait until the previous payload has been read.
// Depends on fdf_pkg, fdf_front, fdf_queue, fdf_back and fdf_ram.
`timescale 1ns / 1ps

module length_framed_byte_deframer #(
  parameter int unsigned MAX_FRAME = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // [7:0] node, [15:8] device, [23:16] payload_byte
  output logic [1:0]  m_axis_tuser_o,  // [0] status, [1] has_payload
  output logic        m_axis_tlast_o
);

  localparam int unsigned AW = $clog2(MAX_FRAME);

  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;
  logic          pay_done;
  fdf_pkg::job_t job_in;
  fdf_pkg::job_t job_out;

  // byte intake and classification
  fdf_front #(
    .MAX_FRAME(MAX_FRAME)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .push_o     (push),
    .job_o      (job_in),
    .q_full_i   (q_full),
    .pay_done_i (pay_done)
  );

  // frame store
  fdf_ram #(
    .WIDTH(8),
    .DEPTH(MAX_FRAME)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // job queue
  fdf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .job_o   (job_out),
    .empty_o (q_empty)
  );

  // result streaming
  fdf_back #(
    .MAX_FRAME(MAX_FRAME)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .job_i       (job_out),
    .pop_o       (pop),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .pay_done_o  (pay_done),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

// ===== test/testbench.sv =====
// self-checking testbench of the length framed byte deframer: directed frames, then random
// frames, noise and overflow runs, each result checked against a predictor or a typed one
// depends on fdf_pkg and length_framed_byte_deframer
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned MAX_FRAME     = 64;
  localparam int unsigned FIXED_LEN     = 9;      // frame bytes other than payload
  localparam int unsigned RAND_ITEMS    = 120;
  localparam int unsigned CALM_AFTER    = 95;     // no idling from here on
  localparam int unsigned QUIET_LIMIT   = 1000;   // cycles without any transaction
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned REPORT_MAX    = 10;
  localparam int          PLAN_ROWS     = 40;

  // one result of the block
  typedef struct packed {
    logic       status;
    logic [7:0] node;
    logic [7:0] device;
    logic [7:0] pay;
    logic       has_pay;
    logic       last;
  } frame_out_t;

  // one directed row: a byte, how often it is sent, and an optional known result
  typedef struct packed {
    logic [7:0] rx;
    logic [7:0] reps;
    logic       typed;
    frame_out_t want;
  } plan_row_t;

  localparam frame_out_t NO_RESULT = '0;
  localparam frame_out_t SHORT7    = '{1'b0, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b1};
  localparam frame_out_t SHORT8    = '{1'b0, 8'hAA, 8'hFF, 8'h00, 1'b0, 1'b1};
  localparam frame_out_t EMPTY9    = '{1'b0, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b1};
  localparam frame_out_t DROPPED   = '{1'b1, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1};

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // shortest frame: tail sits at the node position, device reads as zero
    '{8'hEF, 8'd1, 1'b0, NO_RESULT}, '{8'hEF, 8'd1, 1'b0, NO_RESULT},
    '{8'h00, 8'd1, 1'b0, NO_RESULT}, '{8'h00, 8'd1, 1'b0, NO_RESULT},
    '{8'h00, 8'd1, 1'b0, NO_RESULT}, '{8'h07, 8'd1, 1'b0, NO_RESULT},
    '{8'hFF, 8'd1, 1'b1, SHORT7},
    // length 8: tail sits at the device position
    '{8'hEF, 8'd1, 1'b0, NO_RESULT}, '{8'hEF, 8'd1, 1'b0, NO_RESULT},
    '{8'h00, 8'd1, 1'b0, NO_RESULT}, '{8'h00, 8'd1, 1'b0, NO_RESULT},
    '{8'h00, 8'd1, 1'b0, NO_RESULT}, '{8'h08, 8'd1, 1'b0, NO_RESULT},
    '{8'hAA, 8'd1, 1'b0, NO_RESULT}, '{8'hFF, 8'd1, 1'b1, SHORT8},
    // length 9: empty payload, stray 0xff bytes stored on the way
    '{8'hEF, 8'd1, 1'b0, NO_RESULT}, '{8'hEF, 8'd1, 1'b0, NO_RESULT},
    '{8'hFF, 8'd1, 1'b0, NO_RESULT}, '{8'hFF, 8'd1, 1'b0, NO_RESULT},
    '{8'hFF, 8'd1, 1'b0, NO_RESULT}, '{8'h09, 8'd1, 1'b0, NO_RESULT},
    '{8'h00, 8'd1, 1'b0, NO_RESULT}, '{8'hFF, 8'd1, 1'b0, NO_RESULT},
    '{8'hFF, 8'd1, 1'b1, EMPTY9},
    // restart on a doubled header inside a frame, then two payload bytes
    '{8'hEF, 8'd1, 1'b0, NO_RESULT}, '{8'hEF, 8'd1, 1'b0, NO_RESULT},
    '{8'h12, 8'd1, 1'b0, NO_RESULT}, '{8'hEF, 8'd1, 1'b0, NO_RESULT},
    '{8'hEF, 8'd1, 1'b0, NO_RESULT}, '{8'h34, 8'd1, 1'b0, NO_RESULT},
    '{8'h56, 8'd1, 1'b0, NO_RESULT}, '{8'h78, 8'd1, 1'b0, NO_RESULT},
    '{8'h0B, 8'd1, 1'b0, NO_RESULT}, '{8'h5A, 8'd1, 1'b0, NO_RESULT},
    '{8'hA5, 8'd1, 1'b0, NO_RESULT}, '{8'h00, 8'd1, 1'b0, NO_RESULT},
    '{8'hFF, 8'd1, 1'b0, NO_RESULT}, '{8'hFF, 8'd1, 1'b0, NO_RESULT},
    // buffer overflow: the byte after a nearly full store drops the frame
    '{8'h00, 8'd63, 1'b0, NO_RESULT}, '{8'h00, 8'd1, 1'b1, DROPPED}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = 8'h00;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [23:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  // predictor state
  logic [7:0]  rx_store [MAX_FRAME];
  int unsigned rx_fill = 0;
  frame_out_t  frame_results [$];
  frame_out_t  pending_results [$];

  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sent_cnt = 0;
  int unsigned sink_hold = 0;
  bit          idle_en = 1'b1;

  length_framed_byte_deframer #(
    .MAX_FRAME(MAX_FRAME)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #1 clk_i = ~clk_i;

  // byte at a position of the completed frame, tail and beyond included
  function automatic logic [7:0] framed_byte(int unsigned idx, int unsigned flen);
    if (idx >= flen) return 8'h00;
    if (idx == flen - 1) return fdf_pkg::TAIL_BYTE;
    return rx_store[idx];
  endfunction

  // predictor: takes one received byte and lists the results it causes
  function automatic void deframe_byte(logic [7:0] rx);
    int unsigned flen;
    int unsigned cnt;
    logic [7:0]  nd;
    logic [7:0]  dv;
    frame_results.delete();
    if (rx == fdf_pkg::HDR_BYTE && rx_fill > 0 && rx_store[rx_fill-1] == fdf_pkg::HDR_BYTE) begin
      // doubled header restarts the frame
      rx_store[0] = fdf_pkg::HDR_BYTE;
      rx_store[1] = fdf_pkg::HDR_BYTE;
      rx_fill = 2;
    end else if (rx_fill > fdf_pkg::LEN_POS && rx == fdf_pkg::TAIL_BYTE &&
                 rx_fill + 1 == rx_store[fdf_pkg::LEN_POS]) begin
      // tail at the announced length completes the frame
      flen = rx_fill + 1;
      nd = framed_byte(fdf_pkg::NODE_POS, flen);
      dv = framed_byte(fdf_pkg::DEV_POS, flen);
      rx_fill = 0;
      if (flen <= FIXED_LEN) begin
        frame_results.push_back('{1'b0, nd, dv, 8'h00, 1'b0, 1'b1});
      end else begin
        cnt = flen - FIXED_LEN;
        for (int unsigned n = 0; n < cnt; n++) begin
          frame_results.push_back('{1'b0, nd, dv, framed_byte(fdf_pkg::PAY_POS + n, flen),
                                    1'b1, (n + 1 == cnt)});
        end
      end
    end else if (rx_fill >= MAX_FRAME - 1) begin
      rx_fill = 0;
      frame_results.push_back(DROPPED);
    end else begin
      rx_store[rx_fill] = rx;
      rx_fill++;
    end
  endfunction

  // one input transaction; a typed result replaces the predicted one
  task automatic send_byte(input logic [7:0] rx, input bit typed, input frame_out_t want);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= rx;
    do @(posedge clk_i); while (!s_axis_tready_o);
    deframe_byte(rx);
    if (typed) pending_results.push_back(want);
    else foreach (frame_results[i]) pending_results.push_back(frame_results[i]);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  // well-formed frame of the given total length with random content
  task automatic send_frame(input int unsigned flen);
    send_byte(fdf_pkg::HDR_BYTE, 1'b0, NO_RESULT);
    send_byte(fdf_pkg::HDR_BYTE, 1'b0, NO_RESULT);
    repeat (3) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
    send_byte(8'(flen), 1'b0, NO_RESULT);
    for (int unsigned i = fdf_pkg::NODE_POS; i + 1 < flen; i++) begin
      send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
    end
    send_byte(fdf_pkg::TAIL_BYTE, 1'b0, NO_RESULT);
  endtask

  // hold the sender until every pending result has come out
  task automatic drain_results();
    s_valid <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  // sink ready with random stall bursts
  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold--;
      m_ready <= 1'b0;
    end else if (idle_en && rst_ni && $urandom_range(0, 5) == 0) begin
      sink_hold = $urandom_range(0, 6);
      m_ready <= 1'b0;
    end else begin
      m_ready <= rst_ni;
    end
  end

  // result checking and watchdog
  always @(posedge clk_i) begin
    frame_out_t got;
    frame_out_t want;
    if (rst_ni) begin
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (m_axis_tvalid_o && m_ready) begin
        got = '{m_axis_tuser_o[0], m_axis_tdata_o[7:0], m_axis_tdata_o[15:8],
                m_axis_tdata_o[23:16], m_axis_tuser_o[1], m_axis_tlast_o};
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected result: status %0d node %h device %h byte %h has %0d last %0d",
                     got.status, got.node, got.device, got.pay, got.has_pay, got.last);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.node !== want.node ||
              got.device !== want.device || got.pay !== want.pay ||
              got.has_pay !== want.has_pay || got.last !== want.last) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
              $display("mismatch exp: status %0d node %h device %h byte %h has %0d last %0d",
                       want.status, want.node, want.device, want.pay, want.has_pay, want.last);
              $display("         got: status %0d node %h device %h byte %h has %0d last %0d",
                       got.status, got.node, got.device, got.pay, got.has_pay, got.last);
            end
          end
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int unsigned pick;
    int unsigned r;
    int unsigned flen;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed frames
    foreach (PLAN[k]) begin
      for (int unsigned n = 1; n <= PLAN[k].reps; n++) begin
        send_byte(PLAN[k].rx, PLAN[k].typed && n == PLAN[k].reps, PLAN[k].want);
      end
    end
    drain_results();

    // random part, opened by the longest legal frame
    sent_cnt = 0;
    send_frame(MAX_FRAME);
    while (sent_cnt < RAND_ITEMS) begin
      idle_en = (sent_cnt < CALM_AFTER) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 11) == 0) drain_results();
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        r = $urandom_range(0, 9);
        flen = (r == 0) ? MAX_FRAME :
               (r < 3)  ? $urandom_range(7, FIXED_LEN) : $urandom_range(10, 20);
        send_frame(flen);
      end else if (pick < 17) begin
        // line noise
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
      end else if (pick < 19) begin
        // header followed by a random, likely broken, remainder
        send_byte(fdf_pkg::HDR_BYTE, 1'b0, NO_RESULT);
        send_byte(fdf_pkg::HDR_BYTE, 1'b0, NO_RESULT);
        repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
      end else begin
        // run without header or tail bytes, long enough to overflow
        repeat (MAX_FRAME) send_byte(8'($urandom_range(0, 8'hEE)), 1'b0, NO_RESULT);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/fdf_pkg.sv
rtl/core/fdf_ram.sv
rtl/core/fdf_front.sv
rtl/core/fdf_queue.sv
rtl/core/fdf_back.sv
rtl/core/length_framed_byte_deframer.sv
test/testbench.sv
